>>> hdl/iefg_pkg.sv
// Shared types, constants and checksum helpers for the ICMP echo frame generator.
`timescale 1ns / 1ps
`default_nettype none

package iefg_pkg;

   // Frame geometry
   localparam int unsigned MAX_PAYLOAD   = 470;
   localparam int unsigned HDR_BYTES     = 42;
   localparam int unsigned IP_HDR_BYTES  = 20;
   localparam int unsigned ICMP_HDR_BYTES = 8;
   localparam int unsigned HDR_WORDS     = 6;
   localparam int unsigned BEAT_BYTES    = 8;

   // Header constants
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL     = 8'h45;
   localparam logic [7:0]  IP_PROTO_ICMP  = 8'h01;
   localparam logic [7:0]  ICMP_ECHO_REQ  = 8'h08;

   // Payload sum over one full period of 128 byte pairs
   localparam logic [23:0] PAY_PERIOD_SUM = 24'd4177920;

   // Register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 48;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEST_MAC      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_MAC    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_IP     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOP_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAYLOAD_BYTES = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ECHO_IDENT    = 3'd5;

   // Reset values
   localparam logic [7:0] HOP_LIMIT_RESET     = 8'd64;
   localparam logic [8:0] PAYLOAD_BYTES_RESET = 9'd32;

   typedef struct packed {
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [7:0]  hop_limit;
      logic [8:0]  payload_bytes;
      logic [15:0] echo_ident;
   } cfg_type;

   // One frame ready for the beat builder
   typedef struct packed {
      logic [31:0] target_ip;
      logic [15:0] seq_num;
      logic [15:0] ip_csum;
      logic [15:0] icmp_csum;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // Unfolded 16-bit word sum of payload bytes 0,1,2,... (each mod 256)
   function automatic logic [23:0] payload_sum(input logic [8:0] plen);
      logic [7:0]  pairs;
      logic [6:0]  r;
      logic [6:0]  r_m1;
      logic [13:0] prod;
      logic [23:0] sum;
      pairs = plen[8:1];
      r     = pairs[6:0];
      r_m1  = r - 7'd1;
      prod  = {7'd0, r} * {7'd0, r_m1};
      sum   = {10'd0, prod} + {2'd0, prod, 8'd0} + {17'd0, r};
      if (pairs[7]) begin
         sum = sum + PAY_PERIOD_SUM;
      end
      if (plen[0]) begin
         sum = sum + {8'd0, r, 9'd0};
      end
      return sum;
   endfunction

   // Ones'-complement fold and invert
   function automatic logic [15:0] csum_fold(input logic [23:0] sum);
      logic [16:0] f1;
      logic [15:0] f2;
      f1 = {1'b0, sum[15:0]} + {9'd0, sum[23:16]};
      f2 = f1[15:0] + {15'd0, f1[16]};
      return ~f2;
   endfunction

endpackage

`default_nettype wire

>>> hdl/iefg_req_if.sv
// Request channel: target address and sequence number.
`timescale 1ns / 1ps
`default_nettype none

interface iefg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] target_ip;
   logic [15:0] seq_num;

   modport source (output valid, output target_ip, output seq_num, input ready);
   modport sink   (input valid, input target_ip, input seq_num, output ready);
endinterface

`default_nettype wire

>>> hdl/iefg_rsp_if.sv
// Frame beat channel: 64-bit beats with byte count and end marker.
`timescale 1ns / 1ps
`default_nettype none

interface iefg_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] frame_word;
   logic [3:0]  valid_bytes;
   logic        last_beat;

   modport source (output valid, output frame_word, output valid_bytes, output last_beat,
                   input ready);
   modport sink   (input valid, input frame_word, input valid_bytes, input last_beat,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/iefg_front.sv
// Front end: accepts requests and computes both checksums.
`timescale 1ns / 1ps
`default_nettype none

module iefg_front
   import iefg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   iefg_req_if.sink      req_port,
   input  cfg_type       cfg,
   input  fifo_stat_type fifo_stat,
   output logic          push,
   output desc_type      push_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [15:0] seq_ff, seq_in;
   logic [23:0] pay_ff, pay_in;
   logic        accept;
   logic [15:0] total_len;
   logic [23:0] ip_sum;
   logic [23:0] icmp_sum;

   // Take a request whenever the stage is empty or drains this cycle
   assign req_port.ready = !s1_valid_ff || !fifo_stat.full;
   assign accept         = req_port.valid && req_port.ready;
   assign push           = s1_valid_ff && !fifo_stat.full;

   // Capture request and the payload part of the ICMP sum
   always_comb begin
      s1_valid_in = s1_valid_ff;
      tgt_in      = tgt_ff;
      seq_in      = seq_ff;
      pay_in      = pay_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         tgt_in      = req_port.target_ip;
         seq_in      = req_port.seq_num;
         pay_in      = payload_sum(cfg.payload_bytes);
      end else if (push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      tgt_ff <= tgt_in;
      seq_ff <= seq_in;
      pay_ff <= pay_in;
   end

   // Sum the header words and fold
   always_comb begin
      total_len = 16'(IP_HDR_BYTES + ICMP_HDR_BYTES) + {7'd0, cfg.payload_bytes};
      ip_sum = {8'd0, IP_VER_IHL, 8'h00} + {8'd0, total_len} + {8'd0, seq_ff}
             + {8'd0, cfg.hop_limit, IP_PROTO_ICMP}
             + {8'd0, cfg.source_ip[31:16]} + {8'd0, cfg.source_ip[15:0]}
             + {8'd0, tgt_ff[31:16]} + {8'd0, tgt_ff[15:0]};
      icmp_sum = pay_ff + {8'd0, ICMP_ECHO_REQ, 8'h00} + {8'd0, cfg.echo_ident}
               + {8'd0, seq_ff};
      push_data.target_ip = tgt_ff;
      push_data.seq_num   = seq_ff;
      push_data.ip_csum   = csum_fold(ip_sum);
      push_data.icmp_csum = csum_fold(icmp_sum);
   end

endmodule

`default_nettype wire

>>> hdl/iefg_fifo.sv
// Short descriptor queue between front end and beat builder.
`timescale 1ns / 1ps
`default_nettype none

module iefg_fifo
   import iefg_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  desc_type      push_data,
   input  wire logic     pop,
   output desc_type      pop_data,
   output fifo_stat_type stat
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   desc_type            mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, wr_in;
   logic [PTR_BITS-1:0] rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CNT_FULL);
   assign stat.empty = (cnt_ff == '0);
   assign pop_data   = mem_ff[rd_ff];

   // Advance pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/iefg_back.sv
// Beat builder: walks one frame at a time and emits 64-bit beats.
`timescale 1ns / 1ps
`default_nettype none

module iefg_back
   import iefg_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  cfg_type       cfg,
   input  desc_type      pop_data,
   input  fifo_stat_type fifo_stat,
   output logic          pop,
   iefg_rsp_if.source    rsp_port
);

   logic        busy_ff, busy_in;
   desc_type    desc_ff, desc_in;
   logic [5:0]  beat_ff, beat_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_word_ff, out_word_in;
   logic [3:0]  out_bytes_ff, out_bytes_in;
   logic        out_last_ff, out_last_in;

   logic         advance;
   logic [9:0]   total;
   logic [5:0]   last_idx;
   logic         is_last;
   logic [15:0]  total_len;
   logic [383:0] hdr_vec;
   logic [63:0]  hdr_words [8];
   logic [63:0]  hdr_sel;
   logic [8:0]   pos_base;
   logic [8:0]   pos;
   logic [8:0]   pay_idx;
   logic [9:0]   remain;
   logic [63:0]  word;

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.frame_word  = out_word_ff;
   assign rsp_port.valid_bytes = out_bytes_ff;
   assign rsp_port.last_beat   = out_last_ff;

   // Frame length and beat count
   assign total     = 10'(HDR_BYTES) + {1'b0, cfg.payload_bytes};
   assign last_idx  = 6'((total - 10'd1) >> 3);
   assign is_last   = (beat_ff == last_idx);
   assign advance   = !out_valid_ff || rsp_port.ready;
   assign total_len = 16'(IP_HDR_BYTES + ICMP_HDR_BYTES) + {7'd0, cfg.payload_bytes};

   // Header bytes, first wire byte at the top
   always_comb begin
      hdr_vec = {cfg.dest_mac, cfg.source_mac, ETHERTYPE_IPV4,
                 IP_VER_IHL, 8'h00, total_len, desc_ff.seq_num, 16'h0000,
                 cfg.hop_limit, IP_PROTO_ICMP, desc_ff.ip_csum,
                 cfg.source_ip, desc_ff.target_ip,
                 ICMP_ECHO_REQ, 8'h00, desc_ff.icmp_csum, cfg.echo_ident, desc_ff.seq_num,
                 48'd0};
      for (int k = 0; k < 8; k++) begin
         if (k < HDR_WORDS) begin
            hdr_words[k] = hdr_vec[383 - 64 * k -: 64];
         end else begin
            hdr_words[k] = '0;
         end
      end
      hdr_sel = (beat_ff < 6'(HDR_WORDS)) ? hdr_words[beat_ff[2:0]] : '0;
   end

   // Build the current beat byte by byte
   always_comb begin
      pos_base = {beat_ff, 3'b000};
      word     = '0;
      pos      = '0;
      pay_idx  = '0;
      for (int i = 0; i < BEAT_BYTES; i++) begin
         pos     = pos_base + 9'(i);
         pay_idx = pos - 9'(HDR_BYTES);
         if (pos < 9'(HDR_BYTES)) begin
            word[63 - 8 * i -: 8] = hdr_sel[63 - 8 * i -: 8];
         end else if ({1'b0, pos} < total) begin
            word[63 - 8 * i -: 8] = pay_idx[7:0];
         end
      end
      remain = total - {1'b0, pos_base};
   end

   // Sequence beats and hand off between frames without a gap
   always_comb begin
      busy_in      = busy_ff;
      desc_in      = desc_ff;
      beat_in      = beat_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (advance) begin
         out_valid_in = busy_ff;
         out_word_in  = word;
         out_bytes_in = (remain > 10'(BEAT_BYTES)) ? 4'(BEAT_BYTES) : remain[3:0];
         out_last_in  = is_last;
      end
      if (advance && busy_ff) begin
         if (is_last) begin
            busy_in = !fifo_stat.empty;
            pop     = !fifo_stat.empty;
            beat_in = '0;
         end else begin
            beat_in = beat_ff + 6'd1;
         end
      end else if (!busy_ff && !fifo_stat.empty) begin
         busy_in = 1'b1;
         pop     = 1'b1;
         beat_in = '0;
      end
      if (pop) begin
         desc_in = pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
      desc_ff      <= desc_in;
      out_word_ff  <= out_word_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

endmodule

`default_nettype wire

>>> hdl/icmp_echo_frame_generator.sv
// Top level: config registers, front end, descriptor queue and beat builder.
//
// Each request on req_port (target_ip, seq_num) yields one Ethernet/IPv4/ICMP
// echo-request frame on rsp_port as 64-bit beats, first wire byte in bits
// 63..56. A frame has ceil((42 + payload_bytes) / 8) beats, 6 to 64; the
// last one carries last_beat and its byte count, unused bytes are zero.
// A request passes the front-end register, the queue and the beat builder
// before its first beat leaves the output register. The beat builder sends
// one beat per cycle while rsp_port.ready is high and, with a descriptor
// waiting, starts the next frame in the cycle after a last beat. Checksums
// are computed in the front end, and the queue holds QUEUE_DEPTH finished
// frame descriptors so requests keep being taken while a frame streams.
// The csr port writes dest_mac, source_mac, source_ip, hop_limit,
// payload_bytes (clamped to 470) and echo_ident; write only while idle.
// Reset sets hop_limit to 64, payload_bytes to 32, the rest to 0, and
// empties the queue. When the receiver holds rsp_port.ready low, the
// current beat holds; the queue then fills and req_port.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_frame_generator
   import iefg_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   iefg_req_if.sink                       req_port,
   iefg_rsp_if.source                     rsp_port,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type       cfg_ff, cfg_in;
   desc_type      push_data;
   desc_type      pop_data;
   logic          push;
   logic          pop;
   fifo_stat_type fifo_stat;

   // Register writes, clamp payload length
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEST_MAC:   cfg_in.dest_mac   = csr_write_data;
            CSR_SOURCE_MAC: cfg_in.source_mac = csr_write_data;
            CSR_SOURCE_IP:  cfg_in.source_ip  = csr_write_data[31:0];
            CSR_HOP_LIMIT:  cfg_in.hop_limit  = csr_write_data[7:0];
            CSR_PAYLOAD_BYTES: begin
               cfg_in.payload_bytes = (csr_write_data[8:0] > 9'(MAX_PAYLOAD))
                                    ? 9'(MAX_PAYLOAD) : csr_write_data[8:0];
            end
            CSR_ECHO_IDENT: cfg_in.echo_ident = csr_write_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_mac      <= '0;
         cfg_ff.source_mac    <= '0;
         cfg_ff.source_ip     <= '0;
         cfg_ff.hop_limit     <= HOP_LIMIT_RESET;
         cfg_ff.payload_bytes <= PAYLOAD_BYTES_RESET;
         cfg_ff.echo_ident    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iefg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .cfg       (cfg_ff),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_data (push_data)
   );

   iefg_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   iefg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_data  (pop_data),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .rsp_port  (rsp_port)
   );

endmodule

`default_nettype wire

>>> hdl/iefg_checker.sv
// Port-level checks for the ICMP echo frame generator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iefg_checker
   import iefg_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] frame_word,
   input wire logic [3:0]  valid_bytes,
   input wire logic        last_beat
);

   logic [6:0] beat_idx_ff, beat_idx_in;
   logic [7:0] pending_ff, pending_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Track beat position in frame and frames in flight
   always_comb begin
      beat_idx_in = beat_idx_ff;
      pending_in  = pending_ff;
      if (rsp_take) begin
         beat_idx_in = last_beat ? '0 : beat_idx_ff + 7'd1;
      end
      if (req_take && !(rsp_take && last_beat)) begin
         pending_in = pending_ff + 8'd1;
      end else if (!req_take && rsp_take && last_beat) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_idx_ff <= '0;
         pending_ff  <= '0;
      end else begin
         beat_idx_ff <= beat_idx_in;
         pending_ff  <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_word)
         && $stable(valid_bytes) && $stable(last_beat))
      else $error("beat changed while stalled");

   a_byte_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> valid_bytes != 4'd0 && valid_bytes <= 4'd8
         && (last_beat || valid_bytes == 4'd8))
      else $error("bad byte count");

   a_ethertype: assert property (@(posedge clock) disable iff (reset)
      rsp_take && beat_idx_ff == 7'd1 |-> frame_word[31:16] == ETHERTYPE_IPV4)
      else $error("second beat lacks IPv4 ethertype");

   a_frame_len: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !last_beat |-> beat_idx_ff < 7'd63)
      else $error("frame longer than 64 beats");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("beat without a pending request");

endmodule

bind icmp_echo_frame_generator iefg_checker u_iefg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .frame_word  (rsp_port.frame_word),
   .valid_bytes (rsp_port.valid_bytes),
   .last_beat   (rsp_port.last_beat)
);

`default_nettype wire
